// ===== rtl/core/spd_pkg.sv =====
`default_nettype none

package spd_pkg;

  // Largest payload a frame may carry; also the depth of the payload store.
  localparam int MaxPayload = 32;
  localparam int StoreAw    = $clog2(MaxPayload);
  localparam int LenW       = 7;
  localparam int IdxW       = 6;
  localparam int QueueDepth = 4;
  localparam int QueueAw    = $clog2(QueueDepth);

  localparam logic [7:0] MaxLenByte = 8'(MaxPayload);

  localparam logic [7:0] SyncFirstReset  = 8'd170;
  localparam logic [7:0] SyncSecondReset = 8'd175;

  // Configuration register indexes
  localparam logic [7:0] CfgSyncFirst  = 8'd0;
  localparam logic [7:0] CfgSyncSecond = 8'd1;

  // Request kinds on the receive channel
  localparam logic ReqByte    = 1'b0;
  localparam logic ReqTimeout = 1'b1;

  typedef enum logic [2:0] {
    PhSync1,
    PhSync2,
    PhId,
    PhLen,
    PhData,
    PhSum
  } phase_e;

  typedef enum logic {
    CmdStore,
    CmdEmit
  } cmd_e;

  typedef enum logic {
    BkIdle,
    BkShow
  } back_e;

  // One command from the parser to the packet emitter.
  typedef struct packed {
    cmd_e               kind;
    logic [7:0]         value;  // payload byte for a store, message id for an emit
    logic [LenW-1:0]    len;
    logic [StoreAw-1:0] idx;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/spd_ifs.sv =====
`default_nettype none

interface spd_rx_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] rx_byte;

  modport source (output valid, output req_type, output rx_byte, input ready);
  modport sink   (input valid, input req_type, input rx_byte, output ready);
endinterface

interface spd_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_id;
  logic [6:0] payload_len;
  logic [5:0] byte_index;
  logic [7:0] payload_byte;
  logic       has_data;
  logic       last;

  modport source (output valid, output msg_id, output payload_len, output byte_index,
                  output payload_byte, output has_data, output last, input ready);
  modport sink   (input valid, input msg_id, input payload_len, input byte_index,
                  input payload_byte, input has_data, input last, output ready);
endinterface

interface spd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/sync_packet_deframer_sum8.sv =====
// Framed packet receiver with two-byte sync and 8-bit additive checksum.
//
// rx_i carries one event per transfer: a received byte (req_type 0) or a
// receive timeout (req_type 1). Frames are sync_first, sync_second, id,
// length, payload, checksum; the checksum is the 8-bit sum of all earlier
// frame bytes. cfg_i writes sync_first (index 0) and sync_second (index 1);
// other indexes are ignored, and cfg_i is always ready.
// pkt_o delivers a good packet as one transfer per payload byte, last set
// on the final one; an empty packet gives a single transfer with has_data 0.
// The parser takes one rx transfer per cycle while its 4-entry command
// queue has room. Each payload byte and each good checksum place one
// command in the queue; the emitter drains one store command per cycle
// while idle and shows a packet at one result per cycle while pkt_o is
// ready, taking no command until the packet's last result is taken.
// With the emitter idle the checksum's command is queued, then popped to raise pkt_o.valid.
// When pkt_o stalls the emitter holds its result, the queue fills, and
// rx_i.ready drops once the queue is full.
// Reset returns the parser to the sync hunt, empties the queue and loads
// the sync registers with 0xAA and 0xAF.
`default_nettype none

module sync_packet_deframer_sum8
  import spd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  spd_rx_if.sink    rx_i,
  spd_pkt_if.source pkt_o,
  spd_cfg_if.sink   cfg_i
);

  logic [7:0] sync_first_q, sync_second_q;
  logic       front_valid, front_ready, back_valid, back_ready;
  cmd_t       front_cmd, back_cmd;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= SyncFirstReset;
      sync_second_q <= SyncSecondReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgSyncFirst:  sync_first_q  <= cfg_i.data;
        CfgSyncSecond: sync_second_q <= cfg_i.data;
        default: begin
          sync_first_q <= sync_first_q;
        end
      endcase
    end
  end

  spd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .rx_i          (rx_i),
    .cmd_valid_o   (front_valid),
    .cmd_ready_i   (front_ready),
    .cmd_o         (front_cmd)
  );

  spd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (back_cmd)
  );

  spd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (back_valid),
    .cmd_ready_o (back_ready),
    .cmd_i       (back_cmd),
    .pkt_o       (pkt_o)
  );

endmodule

`default_nettype wire

// ===== rtl/core/spd_front.sv =====
`default_nettype none

module spd_front
  import spd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [7:0] sync_first_i,
  input  wire logic [7:0] sync_second_i,
  spd_rx_if.sink          rx_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_ready_i,
  output cmd_t            cmd_o
);

  phase_e          phase_q, phase_d;
  logic [7:0]      id_q, id_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] fill_q, fill_d;
  logic [7:0]      sum_q, sum_d;
  logic            accept;
  logic [7:0]      c;

  // Take a byte only when the command queue has room for what it may cause.
  assign rx_i.ready = cmd_ready_i;
  assign accept     = rx_i.valid & cmd_ready_i;
  assign c          = rx_i.rx_byte;

  always_comb begin
    phase_d = phase_q;
    id_d    = id_q;
    len_d   = len_q;
    fill_d  = fill_q;
    sum_d   = sum_q;
    if (accept) begin
      if (rx_i.req_type == ReqTimeout) begin
        phase_d = PhSync1;
      end else begin
        case (phase_q)
          PhSync1: begin
            phase_d = (c == sync_first_i) ? PhSync2 : PhSync1;
            sum_d   = c;
          end
          PhSync2: begin
            phase_d = (c == sync_second_i) ? PhId : PhSync1;
            sum_d   = sum_q + c;
          end
          PhId: begin
            id_d    = c;
            sum_d   = sum_q + c;
            phase_d = PhLen;
          end
          PhLen: begin
            if (c <= MaxLenByte) begin
              len_d   = c[LenW-1:0];
              fill_d  = '0;
              sum_d   = sum_q + c;
              phase_d = (c != 8'd0) ? PhData : PhSum;
            end else begin
              phase_d = PhSync1;
            end
          end
          PhData: begin
            fill_d = fill_q + 1'b1;
            sum_d  = sum_q + c;
            if (fill_d >= len_q) begin
              phase_d = PhSum;
            end
          end
          PhSum: begin
            phase_d = PhSync1;
          end
          default: begin
            phase_d = PhSync1;
          end
        endcase
      end
    end
  end

  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_o.kind  = CmdStore;
    cmd_o.value = c;
    cmd_o.len   = len_q;
    cmd_o.idx   = fill_q[StoreAw-1:0];
    if (accept && rx_i.req_type == ReqByte) begin
      case (phase_q)
        PhData: begin
          cmd_valid_o = 1'b1;
        end
        PhSum: begin
          if (sum_q == c) begin
            cmd_valid_o = 1'b1;
            cmd_o.kind  = CmdEmit;
            cmd_o.value = id_q;
          end
        end
        default: begin
          cmd_valid_o = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSync1;
      id_q    <= '0;
      len_q   <= '0;
      fill_q  <= '0;
      sum_q   <= '0;
    end else begin
      phase_q <= phase_d;
      id_q    <= id_d;
      len_q   <= len_d;
      fill_q  <= fill_d;
      sum_q   <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spd_queue.sv =====
`default_nettype none

module spd_queue
  import spd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_valid_i,
  output logic       push_ready_o,
  input  wire cmd_t  push_data_i,
  output logic       pop_valid_o,
  input  wire logic  pop_ready_i,
  output cmd_t       pop_data_o
);

  cmd_t               slots_q [QueueDepth];
  logic [QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueAw:0]   count_q;
  logic               push, pop;

  assign push_ready_o = (count_q != (QueueAw+1)'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spd_back.sv =====
`default_nettype none

module spd_back
  import spd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cmd_valid_i,
  output logic       cmd_ready_o,
  input  wire cmd_t  cmd_i,
  spd_pkt_if.source  pkt_o
);

  logic [7:0]         store_q [MaxPayload];
  logic [7:0]         rd_q;
  back_e              state_q, state_d;
  logic [7:0]         id_q, id_d;
  logic [LenW-1:0]    len_q, len_d;
  logic [StoreAw-1:0] idx_q, idx_d;
  logic               empty_q, empty_d;
  logic               pop, is_last, xfer;

  assign pop     = cmd_valid_i & cmd_ready_o;
  assign xfer    = pkt_o.valid & pkt_o.ready;
  assign is_last = empty_q | ((LenW'(idx_q) + 1'b1) == len_q);

  // Next state
  always_comb begin
    state_d = state_q;
    id_d    = id_q;
    len_d   = len_q;
    idx_d   = idx_q;
    empty_d = empty_q;
    case (state_q)
      BkIdle: begin
        if (pop && cmd_i.kind == CmdEmit) begin
          state_d = BkShow;
          id_d    = cmd_i.value;
          len_d   = cmd_i.len;
          idx_d   = '0;
          empty_d = (cmd_i.len == '0);
        end
      end
      BkShow: begin
        if (xfer) begin
          if (is_last) begin
            state_d = BkIdle;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = BkIdle;
      end
    endcase
  end

  // Outputs
  always_comb begin
    cmd_ready_o        = (state_q == BkIdle);
    pkt_o.valid        = (state_q == BkShow);
    pkt_o.msg_id       = id_q;
    pkt_o.payload_len  = len_q;
    pkt_o.byte_index   = IdxW'(idx_q);
    pkt_o.payload_byte = empty_q ? 8'd0 : rd_q;
    pkt_o.has_data     = ~empty_q;
    pkt_o.last         = is_last;
  end

  // Store writes come only while idle; the read follows the next index so
  // rd_q always holds the entry being shown.
  always_ff @(posedge clk_i) begin
    if (pop && cmd_i.kind == CmdStore) begin
      store_q[cmd_i.idx] <= cmd_i.value;
    end
    rd_q <= store_q[idx_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      id_q    <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      empty_q <= 1'b0;
    end else begin
      state_q <= state_d;
      id_q    <= id_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      empty_q <= empty_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/spd_checker.sv =====
`default_nettype none

module spd_checker
  import spd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       ready_i,
  input wire logic [7:0] msg_id_i,
  input wire logic [6:0] payload_len_i,
  input wire logic [5:0] byte_index_i,
  input wire logic       has_data_i,
  input wire logic       last_i
);

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i && $stable(msg_id_i) && $stable(byte_index_i)
                            && $stable(last_i))
    else $error("stalled packet result changed");

  // An empty packet is a single result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !has_data_i |-> last_i && byte_index_i == 6'd0 && payload_len_i == 7'd0)
    else $error("empty packet result malformed");

  // The last mark sits exactly on the final payload byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && has_data_i |->
      (last_i == ((7'(byte_index_i) + 7'd1) == payload_len_i)))
    else $error("last mark misplaced");

  // After a non-final transfer the next result of the packet follows in order.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_i && has_data_i && !last_i |=>
      valid_i && byte_index_i == $past(byte_index_i) + 6'd1 && $stable(msg_id_i))
    else $error("payload result out of order");

endmodule

bind sync_packet_deframer_sum8 spd_checker u_spd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .valid_i       (pkt_o.valid),
  .ready_i       (pkt_o.ready),
  .msg_id_i      (pkt_o.msg_id),
  .payload_len_i (pkt_o.payload_len),
  .byte_index_i  (pkt_o.byte_index),
  .has_data_i    (pkt_o.has_data),
  .last_i        (pkt_o.last)
);

`default_nettype wire

// ===== tb/tb_sync_packet_deframer_sum8.sv =====
`default_nettype none

module tb_sync_packet_deframer_sum8
  import spd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 16;
  localparam int RandPerPhase = 56;

  // Indexes with no register behind them
  localparam logic [7:0] CfgNoReg = 8'd2;
  localparam logic [7:0] CfgTopIdx = 8'hFF;

  typedef enum logic [2:0] {
    FrGood,
    FrBadSum,
    FrBadSync,
    FrTimeout,
    FrLong
  } frame_fault_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
    logic       drain_first;
  } rx_event_t;

  typedef struct packed {
    logic [7:0]      msg_id;
    logic [LenW-1:0] payload_len;
    logic [IdxW-1:0] byte_index;
    logic [7:0]      payload_byte;
    logic            has_data;
    logic            last;
  } pkt_byte_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  spd_rx_if  rx ();
  spd_pkt_if pkt ();
  spd_cfg_if cfg ();

  logic       rx_valid_q  = 1'b0;
  logic       rx_kind_q   = ReqByte;
  logic [7:0] rx_data_q   = 8'h00;
  logic       pkt_ready_q = 1'b0;
  logic       cfg_valid_q = 1'b0;
  logic [7:0] cfg_index_q = 8'h00;
  logic [7:0] cfg_data_q  = 8'h00;

  assign rx.valid    = rx_valid_q;
  assign rx.req_type = rx_kind_q;
  assign rx.rx_byte  = rx_data_q;
  assign pkt.ready   = pkt_ready_q;
  assign cfg.valid   = cfg_valid_q;
  assign cfg.index   = cfg_index_q;
  assign cfg.data    = cfg_data_q;

  sync_packet_deframer_sum8 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx),
    .pkt_o  (pkt),
    .cfg_i  (cfg)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  rx_event_t rx_events[$];
  pkt_byte_t expected_bytes[$];
  int        pushed = 0;
  int        fail_count = 0;

  // Sync values the stimulus builds frames with
  logic [7:0] stim_first = SyncFirstReset;
  logic [7:0] stim_second = SyncSecondReset;

  // Parser state mirrored by the predictor
  logic [7:0]      sync_a = SyncFirstReset;
  logic [7:0]      sync_b = SyncSecondReset;
  phase_e          parse_ph = PhSync1;
  logic [7:0]      parse_id = 8'h00;
  logic [LenW-1:0] parse_len = '0;
  logic [LenW-1:0] parse_fill = '0;
  logic [7:0]      parse_sum = 8'h00;
  logic [7:0]      parse_store[MaxPayload];

  task automatic predict_deframer(logic kind, logic [7:0] b);
    pkt_byte_t rec;
    if (kind == ReqTimeout) begin
      parse_ph = PhSync1;
      return;
    end
    case (parse_ph)
      PhSync1: begin
        parse_ph = (b == sync_a) ? PhSync2 : PhSync1;
        parse_sum = b;
      end
      PhSync2: begin
        // a wrong second byte is not retried as a first sync
        parse_ph = (b == sync_b) ? PhId : PhSync1;
        parse_sum = parse_sum + b;
      end
      PhId: begin
        parse_id = b;
        parse_sum = parse_sum + b;
        parse_ph = PhLen;
      end
      PhLen: begin
        if (b <= MaxLenByte) begin
          parse_len = b[LenW-1:0];
          parse_fill = '0;
          parse_sum = parse_sum + b;
          parse_ph = (b != 8'h00) ? PhData : PhSum;
        end else begin
          parse_ph = PhSync1;
        end
      end
      PhData: begin
        parse_store[parse_fill[StoreAw-1:0]] = b;
        parse_fill = parse_fill + 1'b1;
        parse_sum = parse_sum + b;
        if (parse_fill >= parse_len) parse_ph = PhSum;
      end
      PhSum: begin
        if (parse_sum == b) begin
          rec.msg_id = parse_id;
          rec.payload_len = parse_len;
          if (parse_len == '0) begin
            rec.byte_index = '0;
            rec.payload_byte = 8'h00;
            rec.has_data = 1'b0;
            rec.last = 1'b1;
            expected_bytes.push_back(rec);
          end else begin
            for (int i = 0; i < int'(parse_len); i++) begin
              rec.byte_index = IdxW'(i);
              rec.payload_byte = parse_store[i];
              rec.has_data = 1'b1;
              rec.last = (i == int'(parse_len) - 1);
              expected_bytes.push_back(rec);
            end
          end
        end
        parse_ph = PhSync1;
      end
      default: parse_ph = PhSync1;
    endcase
  endtask

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Receive-side driver: bursts with random gaps
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk_i) begin
    rx_event_t ev;
    if (rst_ni) begin
      if (rx_valid_q && rx.ready) predict_deframer(rx_kind_q, rx_data_q);
      if (!rx_valid_q || rx.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          rx_valid_q <= 1'b0;
        end else if (rx_events.size() != 0 &&
                     !(rx_events[0].drain_first && expected_bytes.size() != 0)) begin
          ev = rx_events.pop_front();
          rx_valid_q <= 1'b1;
          rx_kind_q <= ev.kind;
          rx_data_q <= ev.data;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          rx_valid_q <= 1'b0;
        end
      end
    end
  end

  // Packet-side monitor: ready follows a rotating stall pattern
  logic [7:0] stall_pat = 8'hFF;
  int         stretch_left = 0;

  always @(posedge clk_i) begin
    pkt_byte_t want;
    if (rst_ni) begin
      if (pkt.valid && pkt_ready_q) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected packet transfer, expected none, actual id %0d idx %0d",
                   $time, pkt.msg_id, pkt.byte_index);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("msg_id", want.msg_id, pkt.msg_id);
          check_field("payload_len", 8'(want.payload_len), 8'(pkt.payload_len));
          check_field("byte_index", 8'(want.byte_index), 8'(pkt.byte_index));
          check_field("payload_byte", want.payload_byte, pkt.payload_byte);
          check_field("has_data", 8'(want.has_data), 8'(pkt.has_data));
          check_field("last", 8'(want.last), 8'(pkt.last));
        end
      end
      if (stretch_left == 0) begin
        stall_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
        stretch_left = $urandom_range(4, 60);
      end else begin
        stretch_left--;
      end
      pkt_ready_q <= stall_pat[0];
      stall_pat = {stall_pat[0], stall_pat[7:1]};
    end
  end

  task automatic push_event(logic kind, logic [7:0] data);
    rx_events.push_back('{kind, data, 1'b0});
    pushed++;
  endtask

  task automatic push_frame(logic [7:0] id, int len, frame_fault_e fault);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    int cut;
    bytes.push_back(stim_first);
    bytes.push_back((fault == FrBadSync) ? stim_second ^ 8'($urandom_range(1, 255))
                                         : stim_second);
    if (fault != FrBadSync) begin
      bytes.push_back(id);
      bytes.push_back(8'(len));
      if (fault != FrLong) begin
        for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
        sum = 8'h00;
        foreach (bytes[i]) sum = sum + bytes[i];
        bytes.push_back((fault == FrBadSum) ? sum ^ 8'($urandom_range(1, 255)) : sum);
      end
    end
    cut = (fault == FrTimeout) ? $urandom_range(0, bytes.size() - 1) : bytes.size();
    foreach (bytes[i]) begin
      if (i < cut) push_event(ReqByte, bytes[i]);
    end
    if (fault == FrTimeout) push_event(ReqTimeout, 8'($urandom));
  endtask

  task automatic cfg_write(logic [7:0] idx, logic [7:0] val);
    @(posedge clk_i);
    cfg_valid_q <= 1'b1;
    cfg_index_q <= idx;
    cfg_data_q <= val;
    do @(posedge clk_i); while (!cfg.ready);
    cfg_valid_q <= 1'b0;
    if (idx == CfgSyncFirst) sync_a = val;
    else if (idx == CfgSyncSecond) sync_b = val;
  endtask

  // Wait until the sender is idle and no packet byte is outstanding
  task automatic settle();
    do @(negedge clk_i);
    while (rx_events.size() != 0 || rx_valid_q || expected_bytes.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  initial begin
    int goal;
    int roll;
    int len;
    int mark;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset sync values, extremes and each drop path
    push_frame(8'h00, 0, FrGood);
    rx_events.push_back('{ReqByte, stim_first, 1'b0});
    pushed++;
    rx_events.push_back('{ReqByte, stim_second, 1'b0});
    pushed++;
    rx_events.push_back('{ReqByte, 8'hFF, 1'b0});
    pushed++;
    rx_events.push_back('{ReqByte, 8'h01, 1'b0});
    pushed++;
    rx_events.push_back('{ReqByte, 8'hFF, 1'b0});
    pushed++;
    rx_events.push_back('{ReqByte, stim_first + stim_second + 8'hFF + 8'h01 + 8'hFF, 1'b0});
    pushed++;
    push_frame(8'h11, 0, FrBadSync);
    push_frame(8'h5A, int'(MaxLenByte) + 1, FrLong);
    push_frame(8'h80, 0, FrBadSum);
    push_event(ReqByte, stim_first);
    push_event(ReqByte, stim_second);
    push_event(ReqTimeout, 8'hFF);
    settle();

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin
          stim_first = 8'h00;
          stim_second = 8'h00;
        end
        1: begin
          stim_first = 8'hFF;
          stim_second = 8'hFF;
        end
        2: begin
          stim_first = 8'h00;
          stim_second = 8'hFF;
        end
        default: begin
          stim_first = 8'($urandom);
          stim_second = 8'($urandom);
        end
      endcase
      cfg_write(CfgSyncFirst, stim_first);
      cfg_write(CfgSyncSecond, stim_second);
      if (p == 1) begin
        // writes to missing registers must leave the syncs alone
        cfg_write(CfgNoReg, 8'h55);
        cfg_write(CfgTopIdx, 8'hAA);
      end

      goal = pushed + RandPerPhase;
      push_frame(8'($urandom), MaxPayload, FrGood);
      mark = rx_events.size() + $urandom_range(4, 30);
      while (pushed < goal) begin
        roll = $urandom_range(0, 99);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MaxPayload)
                                          : $urandom_range(0, 6);
        if (roll < 65) push_frame(8'($urandom), len, FrGood);
        else if (roll < 73) push_frame(8'($urandom), len, FrBadSum);
        else if (roll < 80) push_frame(8'($urandom), len, FrBadSync);
        else if (roll < 87) push_frame(8'($urandom), len, FrTimeout);
        else if (roll < 93) push_frame(8'($urandom), $urandom_range(33, 255), FrLong);
        else if (roll < 97) push_event(ReqTimeout, 8'($urandom));
        else repeat ($urandom_range(1, 3)) push_event(ReqByte, 8'($urandom));
      end
      // hold the sender once per phase until the packet side has drained
      if (mark < rx_events.size()) rx_events[mark].drain_first = 1'b1;
      settle();
    end

    if (fail_count == 0) begin
      $display("sync_packet_deframer_sum8 verification clean");
    end else begin
      $display("sync_packet_deframer_sum8 verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("sync_packet_deframer_sum8 verification failed");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/spd_pkg.sv
rtl/core/spd_ifs.sv
rtl/core/spd_front.sv
rtl/core/spd_queue.sv
rtl/core/spd_back.sv
rtl/core/sync_packet_deframer_sum8.sv
rtl/core/spd_checker.sv
tb/tb_sync_packet_deframer_sum8.sv
